// ===== hdl/hre_pkg.sv =====
// Shared types, constants and character helpers for the hex record encoder.
// Used by hre_front, hre_job_fifo, hre_back and hex_record_encoder.
package hre_pkg;

  localparam int MAX_RECORD_BYTES = 16;
  localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 1);
  localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
  localparam int BANK_ADDR_W = IDX_W + 1;
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);

  localparam logic [6:0] CHR_COLON = 7'h3A;
  localparam logic [6:0] CHR_CR    = 7'h0D;
  localparam logic [6:0] CHR_LF    = 7'h0A;
  localparam logic [3:0] EOF_LAST  = 4'd10;

  typedef enum logic [1:0] {
    OP_ORIGIN = 2'd0,
    OP_DATA   = 2'd1,
    OP_END    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // One closed record and/or end-of-file line to be printed.
  typedef struct packed {
    logic             has_record;
    logic             eof;
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [15:0]      start;
  } job_t;

  // Byte write into the record buffer.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } buf_wr_t;

  // Bank handed back once its record text has gone out.
  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

  // Characters of ":00000001FF".
  function automatic logic [6:0] eof_char(input logic [3:0] pos);
    logic [6:0] c;
    unique case (pos)
      4'd0:          c = CHR_COLON;
      4'd8:          c = 7'h31;
      4'd9, 4'd10:   c = 7'h46;
      default:       c = 7'h30;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/hre_front.sv =====
// Front end: accepts commands, tracks the open record and fills the byte banks.
// Pushes one print job per item that produces text. Depends on hre_pkg.
module hre_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hre_pkg::op_t      op,
  input  logic [7:0]        data_byte,
  input  logic [15:0]       origin_address,
  input  logic              jobq_full,
  output logic              job_push,
  output hre_pkg::job_t     job,
  output hre_pkg::buf_wr_t  buf_wr,
  input  hre_pkg::bank_rel_t bank_rel
);

  logic                      cur_bank, cur_bank_next;
  logic [1:0]                busy, busy_next;
  logic [hre_pkg::CNT_W-1:0] count, count_next;
  logic [15:0]               start, start_next;
  logic [15:0]               load_addr, load_addr_next;
  logic                      open, open_next;

  logic                      accept;
  logic [hre_pkg::CNT_W-1:0] count_eff;
  logic [hre_pkg::CNT_W-1:0] count_inc;
  logic [15:0]               start_eff;
  logic [15:0]               addr_inc;

  // Stall while the bank being filled is still being printed or the queue is full.
  assign in_ready = !busy[cur_bank] && !jobq_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    count_eff      = open ? count : '0;
    start_eff      = open ? start : load_addr;
    count_inc      = count_eff + hre_pkg::CNT_W'(1);
    addr_inc       = load_addr + 16'd1;
    cur_bank_next  = cur_bank;
    busy_next      = busy;
    count_next     = count;
    start_next     = start;
    load_addr_next = load_addr;
    open_next      = open;
    job_push       = 1'b0;
    job            = '0;
    job.bank       = cur_bank;
    job.count      = count;
    job.start      = start;
    buf_wr         = '0;
    buf_wr.bank    = cur_bank;
    buf_wr.idx     = count_eff[hre_pkg::IDX_W-1:0];
    buf_wr.data    = data_byte;

    if (bank_rel.en) begin
      busy_next[bank_rel.bank] = 1'b0;
    end

    if (accept) begin
      unique case (op)
        hre_pkg::OP_ORIGIN: begin
          if (open) begin
            job_push       = 1'b1;
            job.has_record = 1'b1;
          end
          load_addr_next = origin_address;
          start_next     = origin_address;
          count_next     = '0;
          open_next      = 1'b1;
        end
        hre_pkg::OP_DATA: begin
          buf_wr.en      = 1'b1;
          load_addr_next = addr_inc;
          open_next      = 1'b1;
          if (count_inc == hre_pkg::CNT_W'(hre_pkg::MAX_RECORD_BYTES)) begin
            job_push       = 1'b1;
            job.has_record = 1'b1;
            job.count      = count_inc;
            job.start      = start_eff;
            start_next     = addr_inc;
            count_next     = '0;
          end else begin
            start_next = start_eff;
            count_next = count_inc;
          end
        end
        hre_pkg::OP_END: begin
          job_push       = 1'b1;
          job.has_record = open;
          job.eof        = 1'b1;
          open_next      = 1'b0;
          count_next     = '0;
        end
        hre_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end

    // Flip to the other bank once a record leaves this one.
    if (job_push && job.has_record) begin
      busy_next[cur_bank] = 1'b1;
      cur_bank_next       = !cur_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_bank  <= 1'b0;
      busy      <= '0;
      count     <= '0;
      start     <= '0;
      load_addr <= '0;
      open      <= 1'b0;
    end else begin
      cur_bank  <= cur_bank_next;
      busy      <= busy_next;
      count     <= count_next;
      start     <= start_next;
      load_addr <= load_addr_next;
      open      <= open_next;
    end
  end

endmodule

// ===== hdl/hre_job_fifo.sv =====
// Short queue of print jobs between the front end and the character serializer.
// Depends on hre_pkg for the job type and depth.
module hre_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hre_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output hre_pkg::job_t pop_job,
  output logic          empty
);

  hre_pkg::job_t                  entries [hre_pkg::JOBQ_DEPTH];
  logic [hre_pkg::JOBQ_PTR_W-1:0] wr_ptr;
  logic [hre_pkg::JOBQ_PTR_W-1:0] rd_ptr;
  logic [hre_pkg::JOBQ_PTR_W:0]   fill;

  assign full    = (fill == (hre_pkg::JOBQ_PTR_W + 1)'(hre_pkg::JOBQ_DEPTH));
  assign empty   = (fill == '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hdl/hre_back.sv =====
// Back end: holds the two record byte banks and serializes one job at a
// time into ASCII hex record text, char by char. Depends on hre_pkg.
module hre_back (
  input  logic               clk,
  input  logic               rst,
  input  hre_pkg::buf_wr_t   buf_wr,
  input  logic               jobq_empty,
  input  hre_pkg::job_t      jobq_head,
  output logic               jobq_pop,
  output hre_pkg::bank_rel_t bank_rel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_char,
  output logic               out_last
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_COLON = 9'b000000010,
    S_HEAD  = 9'b000000100,
    S_FETCH = 9'b000001000,
    S_DATA  = 9'b000010000,
    S_SUM   = 9'b000100000,
    S_CR    = 9'b001000000,
    S_LF    = 9'b010000000,
    S_EOF   = 9'b100000000
  } state_t;

  logic [7:0] rec_mem [2**hre_pkg::BANK_ADDR_W];
  logic [7:0] rd_data;

  state_t                    st, st_next;
  logic [3:0]                nib, nib_next;
  logic [31:0]               hdr, hdr_next;
  logic [7:0]                sum, sum_next;
  logic [hre_pkg::CNT_W-1:0] bnum, bnum_next;
  logic                      j_bank, j_bank_next;
  logic                      j_eof, j_eof_next;
  logic [hre_pkg::CNT_W-1:0] j_count, j_count_next;

  logic                      can;
  logic                      emit;
  logic [6:0]                ch;
  logic                      lst;
  logic [7:0]                chk;
  logic [hre_pkg::CNT_W-1:0] bnum_inc;

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      rec_mem[{buf_wr.bank, buf_wr.idx}] <= buf_wr.data;
    end
    rd_data <= rec_mem[{j_bank, bnum[hre_pkg::IDX_W-1:0]}];
  end

  assign can      = !out_valid || out_ready;
  assign chk      = 8'd0 - sum;
  assign bnum_inc = bnum + hre_pkg::CNT_W'(1);

  always_comb begin
    st_next      = st;
    nib_next     = nib;
    hdr_next     = hdr;
    sum_next     = sum;
    bnum_next    = bnum;
    j_bank_next  = j_bank;
    j_eof_next   = j_eof;
    j_count_next = j_count;
    jobq_pop     = 1'b0;
    bank_rel     = '0;
    bank_rel.bank = j_bank;
    emit         = 1'b0;
    ch           = hre_pkg::CHR_COLON;
    lst          = 1'b0;

    unique case (st)
      S_IDLE: begin
        if (!jobq_empty) begin
          jobq_pop     = 1'b1;
          j_bank_next  = jobq_head.bank;
          j_eof_next   = jobq_head.eof;
          j_count_next = jobq_head.count;
          hdr_next     = {8'(jobq_head.count), jobq_head.start, 8'h00};
          sum_next     = 8'(jobq_head.count) + jobq_head.start[15:8]
                         + jobq_head.start[7:0];
          bnum_next    = '0;
          nib_next     = '0;
          st_next      = jobq_head.has_record ? S_COLON : S_EOF;
        end
      end
      S_COLON: begin
        ch = hre_pkg::CHR_COLON;
        if (can) begin
          emit    = 1'b1;
          st_next = S_HEAD;
        end
      end
      S_HEAD: begin
        // Length, address and type nibbles, most significant first.
        ch = hre_pkg::hex_char(hdr[31:28]);
        if (can) begin
          emit     = 1'b1;
          hdr_next = {hdr[27:0], 4'h0};
          nib_next = nib + 4'd1;
          if (nib == 4'd7) begin
            nib_next = '0;
            st_next  = (j_count == '0) ? S_SUM : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // Wait for the registered buffer read.
        st_next  = S_DATA;
        nib_next = '0;
      end
      S_DATA: begin
        ch = hre_pkg::hex_char(nib[0] ? rd_data[3:0] : rd_data[7:4]);
        if (can) begin
          emit = 1'b1;
          if (!nib[0]) begin
            nib_next = 4'd1;
          end else begin
            nib_next  = '0;
            sum_next  = sum + rd_data;
            bnum_next = bnum_inc;
            st_next   = (bnum_inc == j_count) ? S_SUM : S_FETCH;
          end
        end
      end
      S_SUM: begin
        ch = hre_pkg::hex_char(nib[0] ? chk[3:0] : chk[7:4]);
        if (can) begin
          emit = 1'b1;
          if (!nib[0]) begin
            nib_next = 4'd1;
          end else begin
            nib_next = '0;
            st_next  = S_CR;
          end
        end
      end
      S_CR: begin
        ch = hre_pkg::CHR_CR;
        if (can) begin
          emit    = 1'b1;
          st_next = S_LF;
        end
      end
      S_LF: begin
        ch  = hre_pkg::CHR_LF;
        lst = !j_eof;
        if (can) begin
          emit        = 1'b1;
          bank_rel.en = 1'b1;
          nib_next    = '0;
          st_next     = j_eof ? S_EOF : S_IDLE;
        end
      end
      S_EOF: begin
        ch  = hre_pkg::eof_char(nib);
        lst = (nib == hre_pkg::EOF_LAST);
        if (can) begin
          emit     = 1'b1;
          nib_next = nib + 4'd1;
          if (nib == hre_pkg::EOF_LAST) begin
            nib_next = '0;
            st_next  = S_IDLE;
          end
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      nib       <= '0;
      bnum      <= '0;
      j_bank    <= 1'b0;
      j_eof     <= 1'b0;
      j_count   <= '0;
      out_valid <= 1'b0;
    end else begin
      st      <= st_next;
      nib     <= nib_next;
      bnum    <= bnum_next;
      j_bank  <= j_bank_next;
      j_eof   <= j_eof_next;
      j_count <= j_count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr <= hdr_next;
    sum <= sum_next;
    if (emit) begin
      out_char <= ch;
      out_last <= lst;
    end
  end

endmodule

// ===== hdl/hex_record_encoder.sv =====
// Intel HEX record encoder: commands in, upper-case ASCII record text out.
// A closed record's job passes through the job queue to the serializer, whose output is registered.
// The serializer handles one job at a time, with a buffer read step before each data byte;
// it holds each character until the receiver takes it, and the end line follows the record.
// The front end takes one item per cycle while a byte bank is free and the job queue has room.
// Reset (rst, synchronous) clears all control state; the byte banks are not cleared.
module hex_record_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] origin_address
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] ascii_char, [7] zero
  output logic        m_tlast    // last_char
);

  logic               job_push;
  hre_pkg::job_t      job_in;
  logic               jobq_full;
  logic               jobq_pop;
  hre_pkg::job_t      jobq_head;
  logic               jobq_empty;
  hre_pkg::buf_wr_t   buf_wr;
  hre_pkg::bank_rel_t bank_rel;
  logic [6:0]         out_char;

  hre_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .op             (hre_pkg::op_t'(s_tuser)),
    .data_byte      (s_tdata[7:0]),
    .origin_address (s_tdata[23:8]),
    .jobq_full      (jobq_full),
    .job_push       (job_push),
    .job            (job_in),
    .buf_wr         (buf_wr),
    .bank_rel       (bank_rel)
  );

  hre_job_fifo u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job_in),
    .full     (jobq_full),
    .pop      (jobq_pop),
    .pop_job  (jobq_head),
    .empty    (jobq_empty)
  );

  hre_back u_back (
    .clk        (clk),
    .rst        (rst),
    .buf_wr     (buf_wr),
    .jobq_empty (jobq_empty),
    .jobq_head  (jobq_head),
    .jobq_pop   (jobq_pop),
    .bank_rel   (bank_rel),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (out_char),
    .out_last   (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule

// ===== tb/hex_record_encoder_checker.sv =====
`timescale 1ns / 100ps
// Checker for hex_record_encoder: watches both stream channels, predicts the record text.
// Compares every character against the prediction. Depends on hre_pkg.
module hex_record_encoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  localparam int REC_MAX = 16;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  text_char_t  expected_text[$];

  logic [7:0]  rec_data [REC_MAX];
  logic [4:0]  rec_len;
  logic [15:0] rec_addr;
  logic [15:0] load_addr;
  logic        rec_open;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [6:0] nibble_char(input logic [3:0] n);
    if (n > 4'd9) begin
      return 7'h41 + {3'b000, n - 4'd10};
    end
    return 7'h30 + {3'b000, n};
  endfunction

  function automatic void put_char(input logic [6:0] c);
    text_char_t t;
    t.ch   = c;
    t.last = 1'b0;
    expected_text.push_back(t);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    put_char(nibble_char(b[7:4]));
    put_char(nibble_char(b[3:0]));
  endfunction

  // Emit the open record as ':' LL AAAA 00 data CC CR LF.
  function automatic void flush_record();
    logic [7:0] sum;
    sum = {3'b000, rec_len} + rec_addr[15:8] + rec_addr[7:0];
    put_char(hre_pkg::CHR_COLON);
    put_byte({3'b000, rec_len});
    put_byte(rec_addr[15:8]);
    put_byte(rec_addr[7:0]);
    put_byte(8'h00);
    for (int i = 0; i < int'(rec_len); i++) begin
      put_byte(rec_data[i]);
      sum = sum + rec_data[i];
    end
    put_byte(8'h00 - sum);
    put_char(hre_pkg::CHR_CR);
    put_char(hre_pkg::CHR_LF);
  endfunction

  function automatic void open_at(input logic [15:0] a);
    rec_addr = a;
    rec_len  = '0;
    rec_open = 1'b1;
  endfunction

  function automatic void encode_item(input hre_pkg::op_t op, input logic [7:0] b,
                                      input logic [15:0] a);
    int before_n;
    before_n = expected_text.size();
    case (op)
      hre_pkg::OP_ORIGIN: begin
        if (rec_open) begin
          flush_record();
        end
        load_addr = a;
        open_at(a);
      end
      hre_pkg::OP_DATA: begin
        if (!rec_open) begin
          open_at(load_addr);
        end
        if (rec_len < REC_MAX) begin
          rec_data[rec_len[3:0]] = b;
          rec_len = rec_len + 5'd1;
        end
        load_addr = load_addr + 16'd1;
        // full record goes out at once, next one opens at the following address
        if (rec_len >= REC_MAX) begin
          flush_record();
          open_at(load_addr);
        end
      end
      hre_pkg::OP_END: begin
        if (rec_open) begin
          flush_record();
        end
        // end-of-file line, no CR LF
        put_char(hre_pkg::CHR_COLON);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(8'hFF);
        rec_open = 1'b0;
        rec_len  = '0;
      end
      default: begin
      end
    endcase
    if (expected_text.size() > before_n) begin
      expected_text[expected_text.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : watch
    text_char_t e;
    if (rst) begin
      expected_text.delete();
      rec_len   = '0;
      rec_addr  = '0;
      load_addr = '0;
      rec_open  = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_item(hre_pkg::op_t'(s_tuser), s_tdata[7:0], s_tdata[23:8]);
      end
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing expected", m_tdata));
        end else begin
          e = expected_text.pop_front();
          if (m_tdata !== {1'b0, e.ch}) begin
            report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                      m_tdata, {1'b0, e.ch}));
          end
          if (m_tlast !== e.last) begin
            report_mismatch($sformatf("last_char %b, expected %b on char 0x%02h",
                                      m_tlast, e.last, {1'b0, e.ch}));
          end
        end
      end
    end
    pending <= expected_text.size();
  end

endmodule

// ===== tb/hex_record_encoder_tb.sv =====
`timescale 1ns / 100ps
// Top of the hex_record_encoder testbench: clock, reset, command stimulus and verdict.
// Depends on hre_pkg, hex_record_encoder and hex_record_encoder_checker.
module hex_record_encoder_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = hre_pkg::OP_NONE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int   src_idle = 0;
  int   snk_stall = 0;
  logic hold_go = 1'b0;
  int   hold_left = 0;
  int   cmds_sent = 0;
  int   fails;
  int   pending;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hex_record_encoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  hex_record_encoder_checker rec_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (fails),
    .pending  (pending)
  );

  // Receiver: random stalls, or a long hold-off once hold_go is seen.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= 400;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  task automatic send_cmd(input hre_pkg::op_t op, input logic [7:0] b,
                          input logic [15:0] a);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {a, b};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    if (op != hre_pkg::OP_NONE) begin
      cmds_sent++;
    end
  endtask

  // Hold the input until every predicted character has come out.
  task automatic wait_text_done();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One optional origin / data run / optional end sequence, or some noise.
  task automatic random_run();
    int          pick;
    int          run_len;
    logic [15:0] a;
    pick = $urandom_range(99);
    if (pick < 7) begin
      send_cmd(hre_pkg::OP_NONE, 8'($urandom), 16'($urandom));
    end else if (pick < 13) begin
      send_cmd(hre_pkg::OP_END, 8'($urandom), 16'($urandom));
    end else begin
      if ($urandom_range(3) != 0) begin
        a = 16'($urandom);
        if ($urandom_range(4) == 0) begin
          a = 16'hFFFF - 16'($urandom_range(20));
        end
        send_cmd(hre_pkg::OP_ORIGIN, 8'($urandom), a);
      end
      run_len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 12);
      repeat (run_len) send_cmd(hre_pkg::OP_DATA, 8'($urandom), 16'($urandom));
      if ($urandom_range(4) == 0) begin
        send_cmd(hre_pkg::OP_END, 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    int phase_start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    src_idle = 18;
    snk_stall <= 18;
    @(posedge clk);

    // directed: data with no record open, address wrap, small checksum,
    // empty records, end with and without an open record, origin with none open
    send_cmd(hre_pkg::OP_DATA, 8'h00, 16'hFFFF);
    send_cmd(hre_pkg::OP_DATA, 8'hFF, 16'h0000);
    send_cmd(hre_pkg::OP_ORIGIN, 8'hFF, 16'hFFFF);
    send_cmd(hre_pkg::OP_DATA, 8'hA5, 16'h0000);
    send_cmd(hre_pkg::OP_DATA, 8'h5A, 16'hFFFF);
    send_cmd(hre_pkg::OP_ORIGIN, 8'h00, 16'h0000);
    send_cmd(hre_pkg::OP_DATA, 8'hFB, 16'h0000);
    send_cmd(hre_pkg::OP_ORIGIN, 8'h00, 16'h1234);
    send_cmd(hre_pkg::OP_ORIGIN, 8'hFF, 16'h1234);
    send_cmd(hre_pkg::OP_END, 8'hFF, 16'hFFFF);
    send_cmd(hre_pkg::OP_END, 8'h00, 16'h0000);
    send_cmd(hre_pkg::OP_ORIGIN, 8'h00, 16'h8000);
    send_cmd(hre_pkg::OP_NONE, 8'hFF, 16'hFFFF);
    for (int i = 0; i < 16; i++) begin
      send_cmd(hre_pkg::OP_DATA, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
               16'($urandom));
    end
    send_cmd(hre_pkg::OP_END, 8'($urandom), 16'($urandom));
    wait_text_done();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle = 0;
          snk_stall <= 0;
        end
        1: begin
          src_idle = 76;
          snk_stall <= 0;
        end
        2: begin
          src_idle = 0;
          snk_stall <= 76;
        end
        default: begin
          src_idle = 18;
          snk_stall <= 18;
        end
      endcase
      if (ph == 0) begin
        // long receiver hold-off while commands keep coming: fill the block
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      phase_start = cmds_sent;
      while (cmds_sent - phase_start < 55) random_run();
      wait_text_done();
    end

    repeat (100) @(posedge clk);
    if (fails == 0) begin
      $display("hex_record_encoder_tb: PASS");
    end else begin
      $display("hex_record_encoder_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("hex_record_encoder_tb: FAIL");
    $finish;
  end

endmodule
